// ===== src/b32e_pkg.sv =====
// ----------------------------------------------------------------------------
// b32e_pkg
// Types and constants shared by the base32 encoder front end, run queue,
// symbol back end and top level.
// ----------------------------------------------------------------------------
package b32e_pkg;

   // Symbol counter width and the width used to compare it with the limit
   localparam int COUNT_WIDTH = 16;
   localparam int LIMIT_WIDTH = 16;
   localparam int CMP_WIDTH   = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

   // Alphabet: 32 characters of 8 bits in four 64-bit words
   localparam int WORD_WIDTH    = 64;
   localparam int NUM_WORDS     = 4;
   localparam int SYM_WIDTH     = 5;
   localparam int CHAR_WIDTH    = 8;
   localparam int MAX_SYMS      = 3;
   localparam int CSR_IDX_WIDTH = 3;

   // Run queue depth
   localparam int QUEUE_DEPTH = 2;

   // Register indexes of the write port
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ALPHABET_0 = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ALPHABET_1 = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ALPHABET_2 = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ALPHABET_3 = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_OUT_LIMIT  = 3'd4;

   localparam logic [LIMIT_WIDTH-1:0] OUT_LIMIT_RESET = 16'hFFFF;

   // One run of symbols caused by one input byte
   typedef struct packed {
      logic [MAX_SYMS-1:0][SYM_WIDTH-1:0] sym;
      logic [1:0]                         num;
      logic [MAX_SYMS-1:0]                msg_end;
   } run_type;

   // Head of the run queue as seen by the back end
   typedef struct packed {
      logic    valid;
      run_type run;
   } head_type;

endpackage

// ===== src/base32_encoder_custom_alphabet_core.sv =====
// Path: a transferred byte's run is written into the run queue, then its first symbol is
// loaded into the result register, from which it can be popped.
// Throughput: bytes enter one per cycle while the two-run queue has room; symbols leave one
// per cycle while the consumer pops, and a byte yields up to 3 symbols (1.6 on average).
// The symbol back end, one alphabet lookup per cycle, sets the sustained rate.
// Reset: synchronous; clears the message state, the queue, the result valid bit and the
// alphabet (to zero) and sets the symbol limit to 65535.
// ----------------------------------------------------------------------------
// base32_encoder_custom_alphabet_core
// Streaming base32 encoder with a software-loaded 32-character alphabet and a
// per-message symbol limit.
// ----------------------------------------------------------------------------
module base32_encoder_custom_alphabet_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_push,
   output logic                                     req_full,
   input  logic [7:0]                               req_data_byte,
   input  logic                                     req_final_byte,
   output logic                                     rsp_empty,
   input  logic                                     rsp_pop,
   output logic [7:0]                               rsp_symbol_char,
   output logic                                     rsp_run_end,
   output logic                                     rsp_message_end,
   input  logic                                     csr_write_en,
   input  logic [b32e_pkg::CSR_IDX_WIDTH-1:0]       csr_index,
   input  logic [b32e_pkg::WORD_WIDTH-1:0]          csr_wdata
);

   logic [b32e_pkg::NUM_WORDS-1:0][b32e_pkg::WORD_WIDTH-1:0] alphabet_ff, alphabet_in;
   logic [b32e_pkg::LIMIT_WIDTH-1:0]                        limit_ff, limit_in;

   logic                 accept;
   logic                 run_push;
   b32e_pkg::run_type    run_data;
   b32e_pkg::head_type   head;
   logic                 head_pop;
   logic                 queue_full;

   // Configuration registers
   always_comb begin
      alphabet_in = alphabet_ff;
      limit_in    = limit_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            b32e_pkg::CSR_ALPHABET_0: alphabet_in[0] = csr_wdata;
            b32e_pkg::CSR_ALPHABET_1: alphabet_in[1] = csr_wdata;
            b32e_pkg::CSR_ALPHABET_2: alphabet_in[2] = csr_wdata;
            b32e_pkg::CSR_ALPHABET_3: alphabet_in[3] = csr_wdata;
            b32e_pkg::CSR_OUT_LIMIT:  limit_in       = csr_wdata[b32e_pkg::LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alphabet_ff <= '0;
         limit_ff    <= b32e_pkg::OUT_LIMIT_RESET;
      end else begin
         alphabet_ff <= alphabet_in;
         limit_ff    <= limit_in;
      end
   end

   // Input transfer
   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;

   b32e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .final_byte (req_final_byte),
      .out_limit  (limit_ff),
      .run_push   (run_push),
      .run_data   (run_data)
   );

   b32e_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (run_push),
      .push_data (run_data),
      .pop       (head_pop),
      .head      (head),
      .full      (queue_full)
   );

   b32e_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .alphabet        (alphabet_ff),
      .rsp_pop         (rsp_pop),
      .head_pop        (head_pop),
      .rsp_empty       (rsp_empty),
      .rsp_symbol_char (rsp_symbol_char),
      .rsp_run_end     (rsp_run_end),
      .rsp_message_end (rsp_message_end)
   );

endmodule

// ===== src/b32e_front.sv =====
// ----------------------------------------------------------------------------
// b32e_front
// Takes message bytes, splits them into 5-bit groups with the leftover bits,
// applies the per-message symbol limit and pushes at most one run per byte.
// ----------------------------------------------------------------------------
module b32e_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [7:0]                          data_byte,
   input  logic                                final_byte,
   input  logic [b32e_pkg::LIMIT_WIDTH-1:0]    out_limit,
   output logic                                run_push,
   output b32e_pkg::run_type                   run_data
);

   logic [3:0]                          leftover_bits_ff, leftover_bits_in;
   logic [2:0]                          leftover_count_ff, leftover_count_in;
   logic [b32e_pkg::COUNT_WIDTH-1:0]    count_ff, count_in;

   logic [11:0]                         acc;
   logic [2:0]                          cnt;
   logic [3:0]                          total;
   logic [3:0]                          t1;
   logic [3:0]                          t2;
   logic [3:0]                          rem;
   logic [3:0]                          rest;
   logic [4:0]                          pad;
   logic [b32e_pkg::MAX_SYMS-1:0][4:0]  syms;
   logic [1:0]                          n;
   logic [b32e_pkg::COUNT_WIDTH-1:0]    c;
   logic [b32e_pkg::CMP_WIDTH-1:0]      lim;
   logic                                stop;
   logic [1:0]                          e;
   logic [b32e_pkg::MAX_SYMS-1:0]       last;

   // Split the bit stream into groups
   always_comb begin
      acc   = {leftover_bits_ff, data_byte};
      cnt   = (leftover_count_ff > 3'd4) ? 3'd4 : leftover_count_ff;
      total = {1'b0, cnt} + 4'd8;
      t1    = total - 4'd5;
      t2    = total - 4'd10;
      syms  = '0;
      syms[0] = 5'(acc >> t1);
      if (total >= 4'd10) begin
         syms[1] = 5'(acc >> t2);
         rem     = t2;
         n       = 2'd2;
      end else begin
         rem = t1;
         n   = 2'd1;
      end
      rest = 4'(acc & ((12'd1 << rem) - 12'd1));
      pad  = 5'({1'b0, rest} << (4'd5 - rem));
      // Flush a partial group on the final byte
      if (final_byte && rem != 4'd0) begin
         syms[n] = pad;
         n       = n + 2'd1;
      end
   end

   // Apply the symbol limit one symbol at a time
   always_comb begin
      c    = count_ff;
      lim  = b32e_pkg::CMP_WIDTH'(out_limit);
      stop = 1'b0;
      e    = 2'd0;
      last = '0;
      for (int k = 0; k < b32e_pkg::MAX_SYMS; k++) begin
         if (2'(k) < n && !stop) begin
            if (b32e_pkg::CMP_WIDTH'(c) >= lim) begin
               stop = 1'b1;
            end else begin
               if (c != '1) begin
                  c = c + 1'b1;
               end
               last[k] = (b32e_pkg::CMP_WIDTH'(c) >= lim) ||
                         (final_byte && 2'(k) == n - 2'd1);
               e = e + 2'd1;
            end
         end
      end
   end

   // Next message state
   always_comb begin
      leftover_bits_in  = leftover_bits_ff;
      leftover_count_in = leftover_count_ff;
      count_in          = count_ff;
      if (accept) begin
         if (final_byte) begin
            leftover_bits_in  = '0;
            leftover_count_in = '0;
            count_in          = '0;
         end else begin
            leftover_bits_in  = rest;
            leftover_count_in = rem[2:0];
            count_in          = c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leftover_bits_ff  <= '0;
         leftover_count_ff <= '0;
         count_ff          <= '0;
      end else begin
         leftover_bits_ff  <= leftover_bits_in;
         leftover_count_ff <= leftover_count_in;
         count_ff          <= count_in;
      end
   end

   // Push a run when at least one symbol survives the limit
   assign run_push         = accept && (e != 2'd0);
   assign run_data.sym     = syms;
   assign run_data.num     = e;
   assign run_data.msg_end = last;

endmodule

// ===== src/b32e_queue.sv =====
// ----------------------------------------------------------------------------
// b32e_queue
// Short run queue between the front end and the symbol back end.
// ----------------------------------------------------------------------------
module b32e_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b32e_pkg::run_type   push_data,
   input  logic                pop,
   output b32e_pkg::head_type  head,
   output logic                full
);

   b32e_pkg::run_type  entry_ff [b32e_pkg::QUEUE_DEPTH];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         fill_ff, fill_in;
   logic               do_pop;

   assign full   = (fill_ff == 2'(b32e_pkg::QUEUE_DEPTH));
   assign do_pop = pop && (fill_ff != 2'd0);

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + (push ? 2'd1 : 2'd0) - (do_pop ? 2'd1 : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the pushed run
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head.valid = (fill_ff != 2'd0);
   assign head.run   = entry_ff[rd_ptr_ff];

endmodule

// ===== src/b32e_back.sv =====
// ----------------------------------------------------------------------------
// b32e_back
// Walks the queue head's run one symbol per cycle while the result register
// is free or draining, maps each symbol through the alphabet and holds it there.
// ----------------------------------------------------------------------------
module b32e_back (
   input  logic                                                     clock,
   input  logic                                                     reset,
   input  b32e_pkg::head_type                                       head,
   input  logic [b32e_pkg::NUM_WORDS*b32e_pkg::WORD_WIDTH-1:0]      alphabet,
   input  logic                                                     rsp_pop,
   output logic                                                     head_pop,
   output logic                                                     rsp_empty,
   output logic [b32e_pkg::CHAR_WIDTH-1:0]                          rsp_symbol_char,
   output logic                                                     rsp_run_end,
   output logic                                                     rsp_message_end
);

   logic [1:0]                         idx_ff, idx_in;
   logic                               out_valid_ff, out_valid_in;
   logic [b32e_pkg::CHAR_WIDTH-1:0]    char_ff, char_in;
   logic                               run_end_ff, run_end_in;
   logic                               msg_end_ff, msg_end_in;
   logic                               load;
   logic                               last;
   logic [b32e_pkg::SYM_WIDTH-1:0]     sym;

   // Load from a valid head whenever the result register is free or draining
   assign load = head.valid && (!out_valid_ff || rsp_pop);
   assign last = (idx_ff == head.run.num - 2'd1);
   assign sym  = head.run.sym[idx_ff];

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      char_in      = char_ff;
      run_end_in   = run_end_ff;
      msg_end_in   = msg_end_ff;
      if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         out_valid_in = 1'b1;
         char_in      = alphabet[{sym, 3'b000} +: b32e_pkg::CHAR_WIDTH];
         run_end_in   = last;
         msg_end_in   = head.run.msg_end[idx_ff];
         idx_in       = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      char_ff    <= char_in;
      run_end_ff <= run_end_in;
      msg_end_ff <= msg_end_in;
   end

   assign head_pop        = load && last;
   assign rsp_empty       = !out_valid_ff;
   assign rsp_symbol_char = char_ff;
   assign rsp_run_end     = run_end_ff;
   assign rsp_message_end = msg_end_ff;

endmodule
